/* rtl/mpn_pkg.sv */
// Shared types and constants of the MDI-X pair and polarity negotiation block.
package mpn_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned MOD_W = 7;
	localparam int unsigned PERIOD_W = 8;
	localparam int unsigned CMD_W = 3;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned PADDR_W = 3;

	localparam logic [WORD_W-1:0] LCG_MUL = 32'd214017;
	localparam logic [WORD_W-1:0] LCG_ADD = 32'd2531017;
	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every 32-bit x.
	localparam logic [WORD_W-1:0] RECIP_100 = 32'h51EB851F;
	localparam int unsigned RECIP_SHIFT = 37;

	localparam logic [PERIOD_W-1:0] PERIOD_BASE = 8'd50;
	localparam logic [COUNT_W-1:0] AUTO_TIMEOUT_POLLS = 8'd100;
	localparam logic [COUNT_W-1:0] HIT_LIMIT = 8'd5;
	localparam logic [COUNT_W-1:0] P_MISS_LIMIT = 8'd4;
	localparam logic [COUNT_W-1:0] MISS_LIMIT = 8'd15;
	localparam logic [COUNT_W-1:0] SWAP_TRIES = 8'd8;

	// Register index is taken from paddr[2]; only the seed register exists.
	localparam logic REG_RAND_SEED = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE       = 3'd0,
		CMD_SWAP       = 3'd1,
		CMD_SET_P      = 3'd2,
		CMD_SET_N      = 3'd3,
		CMD_SET_AUTO   = 3'd4,
		CMD_WRITE_AUTO = 3'd5,
		CMD_PHY_RESET  = 3'd6
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		TRIAL_P    = 2'd0,
		TRIAL_N    = 2'd1,
		TRIAL_AUTO = 2'd2
	} trial_t;

	typedef enum logic [1:0] {
		PAIR_IDLE   = 2'd0,
		PAIR_DETECT = 2'd1,
		PAIR_DONE   = 2'd2
	} pair_step_t;

	typedef struct packed {
		logic              load;
		logic [WORD_W-1:0] seed;
	} seed_load_t;

	typedef struct packed {
		logic             busy;
		logic [MOD_W-1:0] cur_mod;
		logic [MOD_W-1:0] next_mod;
	} rng_status_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [PERIOD_W-1:0] period;
		trial_t              trial;
	} poll_result_t;

endpackage

/* rtl/mpn_poll_if.sv */
// Poll channel: one negotiation poll per transaction.
interface mpn_poll_if;
	logic valid;
	logic ready;
	logic partner_seen;
	logic autoneg_done;

	modport source(output valid, output partner_seen, output autoneg_done, input ready);
	modport sink(input valid, input partner_seen, input autoneg_done, output ready);
endinterface

/* rtl/mpn_result_if.sv */
// Result channel: PHY command, next poll period and polarity mode per transaction.
interface mpn_result_if;
	logic                           valid;
	logic                           ready;
	logic [mpn_pkg::CMD_W-1:0]      phy_command;
	logic [mpn_pkg::PERIOD_W-1:0]   next_period_ms;
	logic [mpn_pkg::MODE_W-1:0]     polarity_mode;

	modport source(output valid, output phy_command, output next_period_ms,
		output polarity_mode, input ready);
	modport sink(input valid, input phy_command, input next_period_ms,
		input polarity_mode, output ready);
endinterface

/* rtl/mdix_polarity_negotiation_fsm_unit.sv */
// Top level of the MDI-X pair swap and P/N polarity negotiation controller.
//
// Each poll transaction on the poll channel carries partner_seen and
// autoneg_done; every poll yields exactly one result transaction with the PHY
// command, the period until the next poll (50 to 149 ms) and the polarity mode.
// A poll is captured into an input register and, once the result register is
// free, decided into the result register, from which the result is offered.
// One poll is accepted per cycle while poll ready is high; the next poll may be
// taken while a result waits, since the input register and the result register
// separate the sides. The LCG runs ahead of the polls: the residues mod 100 of
// the current word and of the next one are held ready, so an advance of the
// generator does not stall the polls. When the result receiver stalls, the
// result is held and the input register fills; then poll ready drops until the
// result is taken. After reset, and after every write of the seed register, the
// generator refills its look-ahead words; poll ready is low while it does.
// Reset returns the negotiation to automatic polarity with all counters cleared
// and the seed at zero.
module mdix_polarity_negotiation_fsm_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	mpn_poll_if.sink                     poll,
	mpn_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mpn_pkg::PADDR_W-1:0]  paddr,
	input  logic [mpn_pkg::WORD_W-1:0]   pwdata,
	output logic [mpn_pkg::WORD_W-1:0]   prdata,
	output logic                         pready
);
	mpn_pkg::seed_load_t   seed_load;
	mpn_pkg::rng_status_t  rng_status;
	mpn_pkg::poll_result_t decision;
	logic                  rng_advance;
	logic                  valid_s1;
	logic                  partner_s1;
	logic                  autoneg_s1;
	logic                  out_valid_q;
	logic                  decide;
	logic [mpn_pkg::CMD_W-1:0]    cmd_q;
	logic [mpn_pkg::PERIOD_W-1:0] period_q;
	logic [mpn_pkg::MODE_W-1:0]   mode_q;

	mpn_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.seed_load (seed_load)
	);

	mpn_rng u_rng (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_load (seed_load),
		.advance   (rng_advance),
		.status    (rng_status)
	);

	mpn_negotiate u_neg (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (decide),
		.partner_seen (partner_s1),
		.autoneg_done (autoneg_s1),
		.rng          (rng_status),
		.rng_advance  (rng_advance),
		.result       (decision)
	);

	// The poll in the input register is decided when the result register is free.
	assign decide     = valid_s1 && (!out_valid_q || result.ready);
	assign poll.ready = (!valid_s1 || decide) && !rng_status.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end else if (decide) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			partner_s1 <= poll.partner_seen;
			autoneg_s1 <= poll.autoneg_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (decide) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			cmd_q    <= decision.cmd;
			period_q <= decision.period;
			mode_q   <= decision.trial;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.phy_command    = cmd_q;
	assign result.next_period_ms = period_q;
	assign result.polarity_mode  = mode_q;
endmodule

/* rtl/mpn_cfg_regs.sv */
// APB-style register file holding the random generator seed.
module mpn_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mpn_pkg::PADDR_W-1:0]  paddr,
	input  logic [mpn_pkg::WORD_W-1:0]   pwdata,
	output logic [mpn_pkg::WORD_W-1:0]   prdata,
	output logic                         pready,
	output mpn_pkg::seed_load_t          seed_load
);
	logic                        wr_en;
	logic                        sel_seed;
	logic [mpn_pkg::WORD_W-1:0]  rand_seed_q;

	assign pready   = 1'b1;
	assign sel_seed = (paddr[2] == mpn_pkg::REG_RAND_SEED);
	assign wr_en    = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rand_seed_q <= '0;
		end else if (wr_en && sel_seed) begin
			rand_seed_q <= pwdata;
		end
	end

	assign prdata = sel_seed ? rand_seed_q : '0;

	assign seed_load.load = wr_en && sel_seed;
	assign seed_load.seed = pwdata;
endmodule

/* rtl/mpn_rng.sv */
// Look-ahead LCG: keeps the residues mod 100 of the current and next random words ready.
module mpn_rng (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mpn_pkg::seed_load_t   seed_load,
	input  logic                  advance,
	output mpn_pkg::rng_status_t  status
);
	// word2_q runs two words ahead of the current one.
	// mod0_q and mod1_q are the residues of the current word and of the word after it.
	logic [mpn_pkg::WORD_W-1:0]   word2_q;
	logic [mpn_pkg::MOD_W-1:0]    mod0_q;
	logic [mpn_pkg::MOD_W-1:0]    mod1_q;
	logic [1:0]                   fill_q;
	logic                         shift;
	logic [2*mpn_pkg::WORD_W-1:0] recip_prod;
	logic [mpn_pkg::WORD_W-1:0]   quot;
	logic [mpn_pkg::WORD_W-1:0]   quot_x100;
	logic [mpn_pkg::WORD_W-1:0]   rem;
	logic [mpn_pkg::WORD_W-1:0]   lcg_next;

	assign shift = advance || (fill_q != 2'd0);

	// Remainder by 100 through the reciprocal; times 100 is 64 + 32 + 4.
	assign recip_prod = {{mpn_pkg::WORD_W{1'b0}}, word2_q}
		* {{mpn_pkg::WORD_W{1'b0}}, mpn_pkg::RECIP_100};
	assign quot       = mpn_pkg::WORD_W'(recip_prod >> mpn_pkg::RECIP_SHIFT);
	assign quot_x100  = (quot << 6) + (quot << 5) + (quot << 2);
	assign rem        = word2_q - quot_x100;

	assign lcg_next = word2_q * mpn_pkg::LCG_MUL + mpn_pkg::LCG_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word2_q <= '0;
			fill_q  <= 2'd2;
		end else if (seed_load.load) begin
			word2_q <= seed_load.seed;
			fill_q  <= 2'd2;
		end else if (shift) begin
			word2_q <= lcg_next;
			if (fill_q != 2'd0) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift && !seed_load.load) begin
			mod1_q  <= rem[mpn_pkg::MOD_W-1:0];
			mod0_q  <= mod1_q;
		end
	end

	assign status.busy     = (fill_q != 2'd0);
	assign status.cur_mod  = mod0_q;
	assign status.next_mod = mod1_q;
endmodule

/* rtl/mpn_negotiate.sv */
// Negotiation state and the per-poll decision on command, period and polarity.
module mpn_negotiate (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  partner_seen,
	input  logic                  autoneg_done,
	input  mpn_pkg::rng_status_t  rng,
	output logic                  rng_advance,
	output mpn_pkg::poll_result_t result
);
	mpn_pkg::pair_step_t          pair_step_q, pair_step_d;
	logic [mpn_pkg::COUNT_W-1:0]  pair_tries_q, pair_tries_d;
	logic                         awaiting_q, awaiting_d;
	mpn_pkg::trial_t              trial_q, trial_d;
	logic [mpn_pkg::COUNT_W-1:0]  miss_q, miss_d;
	logic [mpn_pkg::COUNT_W-1:0]  hit_q, hit_d;

	always_comb begin
		logic [mpn_pkg::COUNT_W-1:0] tries_inc;
		logic                        restart;
		mpn_pkg::cmd_t               cmd;
		logic [mpn_pkg::PERIOD_W-1:0] period;

		pair_step_d  = pair_step_q;
		pair_tries_d = pair_tries_q;
		awaiting_d   = awaiting_q;
		trial_d      = trial_q;
		miss_d       = miss_q;
		hit_d        = hit_q;
		restart      = 1'b0;
		cmd          = mpn_pkg::CMD_NONE;
		tries_inc    = pair_tries_q + 8'd1;

		if (pair_step_q == mpn_pkg::PAIR_DETECT) begin
			period = {1'b0, rng.next_mod} + mpn_pkg::PERIOD_BASE;
		end else begin
			period = mpn_pkg::PERIOD_BASE;
		end

		if (partner_seen) begin
			if (pair_step_q == mpn_pkg::PAIR_IDLE) begin
				// First sight of a partner: try the swap, period from the current word.
				pair_step_d  = mpn_pkg::PAIR_DETECT;
				pair_tries_d = 8'd1;
				period       = {1'b0, rng.cur_mod} + mpn_pkg::PERIOD_BASE;
				cmd          = mpn_pkg::CMD_SWAP;
			end else begin
				if (pair_step_q == mpn_pkg::PAIR_DETECT) begin
					pair_step_d  = mpn_pkg::PAIR_DONE;
					pair_tries_d = '0;
				end
				if (!awaiting_q) begin
					if (trial_q == mpn_pkg::TRIAL_AUTO) begin
						trial_d = mpn_pkg::TRIAL_P;
						cmd     = mpn_pkg::CMD_SET_P;
					end else begin
						awaiting_d = 1'b1;
					end
				end else begin
					hit_d = hit_q + 8'd1;
					if (hit_q == mpn_pkg::HIT_LIMIT && !autoneg_done) begin
						hit_d = '0;
						if (trial_q == mpn_pkg::TRIAL_N) begin
							trial_d = mpn_pkg::TRIAL_P;
							cmd     = mpn_pkg::CMD_SET_P;
						end else begin
							trial_d = mpn_pkg::TRIAL_N;
							cmd     = mpn_pkg::CMD_SET_N;
						end
					end
				end
				miss_d = '0;
			end
		end else begin
			if (pair_step_q == mpn_pkg::PAIR_DETECT) begin
				if (tries_inc == mpn_pkg::SWAP_TRIES) begin
					pair_tries_d = '0;
					pair_step_d  = mpn_pkg::PAIR_IDLE;
					cmd          = mpn_pkg::CMD_WRITE_AUTO;
				end else begin
					pair_tries_d = tries_inc;
					cmd          = mpn_pkg::CMD_SWAP;
				end
			end else begin
				miss_d = miss_q + 8'd1;
				if (awaiting_q) begin
					if (miss_q == mpn_pkg::MISS_LIMIT) begin
						restart = 1'b1;
						cmd     = mpn_pkg::CMD_SET_AUTO;
					end
				end else begin
					case (trial_q)
						mpn_pkg::TRIAL_P: begin
							if (miss_q == mpn_pkg::P_MISS_LIMIT) begin
								miss_d  = '0;
								trial_d = mpn_pkg::TRIAL_N;
								cmd     = mpn_pkg::CMD_SET_N;
							end
						end
						mpn_pkg::TRIAL_N: begin
							if (miss_q == mpn_pkg::MISS_LIMIT) begin
								restart = 1'b1;
								cmd     = mpn_pkg::CMD_SET_AUTO;
							end
						end
						default: begin
							if (miss_q == mpn_pkg::AUTO_TIMEOUT_POLLS) begin
								restart = 1'b1;
								cmd     = mpn_pkg::CMD_PHY_RESET;
							end
						end
					endcase
				end
			end
		end

		if (restart) begin
			miss_d      = '0;
			hit_d       = '0;
			pair_step_d = mpn_pkg::PAIR_IDLE;
			awaiting_d  = 1'b0;
			trial_d     = mpn_pkg::TRIAL_AUTO;
		end

		result.cmd    = cmd;
		result.period = period;
		result.trial  = trial_d;
	end

	// The generator steps once for every poll that starts during pair detection.
	assign rng_advance = en && (pair_step_q == mpn_pkg::PAIR_DETECT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_step_q  <= mpn_pkg::PAIR_IDLE;
			pair_tries_q <= '0;
			awaiting_q   <= 1'b0;
			trial_q      <= mpn_pkg::TRIAL_AUTO;
			miss_q       <= '0;
			hit_q        <= '0;
		end else if (en) begin
			pair_step_q  <= pair_step_d;
			pair_tries_q <= pair_tries_d;
			awaiting_q   <= awaiting_d;
			trial_q      <= trial_d;
			miss_q       <= miss_d;
			hit_q        <= hit_d;
		end
	end
endmodule
